// ----- sv/dltq_pkg.sv -----
package dltq_pkg;

	typedef enum logic [1:0] {
		REQ_ADD      = 2'd0,
		REQ_MODIFY   = 2'd1,
		REQ_REMOVE   = 2'd2,
		REQ_DISPATCH = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REMOVE,
		ST_ADD,
		ST_DISP,
		ST_ANSWER
	} state_t;

	// Command broadcast to every cell of the chain.
	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_INSERT,
		CMD_DELETE,
		CMD_POP,
		CMD_AGE
	} cmd_t;

endpackage

// ----- sv/dltq_cell.sv -----
module dltq_cell import dltq_pkg::*; #(
	parameter int ID_BITS   = 4,
	parameter int TICK_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	input  logic                 sel,
	input  logic                 after,
	input  logic [ID_BITS-1:0]   new_slot,
	input  logic [TICK_BITS-1:0] new_delta,
	input  logic [TICK_BITS-1:0] age,
	input  logic                 prev_used,
	input  logic [ID_BITS-1:0]   prev_slot,
	input  logic [TICK_BITS-1:0] prev_delta,
	input  logic                 next_used,
	input  logic [ID_BITS-1:0]   next_slot,
	input  logic [TICK_BITS-1:0] next_delta,
	output logic                 used,
	output logic [ID_BITS-1:0]   slot,
	output logic [TICK_BITS-1:0] delta
);

	logic                 used_q;
	logic [ID_BITS-1:0]   slot_q;
	logic [TICK_BITS-1:0] delta_q;

	assign used  = used_q;
	assign slot  = slot_q;
	assign delta = delta_q;

	// sel marks the cell hit by the command; after marks cells behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else begin
			case (cmd)
				CMD_INSERT: begin
					if (sel) begin
						used_q <= 1'b1;
					end else if (after) begin
						used_q <= prev_used;
					end
				end
				CMD_DELETE: begin
					if (sel || after) begin
						used_q <= next_used;
					end
				end
				CMD_POP: begin
					used_q <= next_used;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			CMD_INSERT: begin
				if (sel) begin
					slot_q  <= new_slot;
					delta_q <= new_delta;
				end else if (after) begin
					slot_q  <= prev_slot;
					delta_q <= prev_delta;
				end
			end
			CMD_DELETE: begin
				if (sel) begin
					slot_q  <= next_slot;
					delta_q <= next_delta + delta_q;
				end else if (after) begin
					slot_q  <= next_slot;
					delta_q <= next_delta;
				end
			end
			CMD_POP: begin
				slot_q  <= next_slot;
				delta_q <= next_delta;
			end
			CMD_AGE: begin
				if (sel) begin
					delta_q <= (delta_q > age) ? delta_q - age : '0;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- sv/delta_list_timer_queue.sv -----
// Add walks past the queue entries that expire no later than the new timer, one entry
// per cycle, and then inserts; remove deletes the entry; modify removes and then adds;
// dispatch gives one notice per cycle for each expired timer while the output register
// has room. A full output register holds back the final answer.
// Throughput: one request at a time; the next is taken in the cycle after the final
// answer enters the output register. Reset clears the queue length and all active bits.
module delta_list_timer_queue import dltq_pkg::*; #(
	parameter int NUM_TIMERS = 16,
	parameter int TICK_BITS  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [3:0]  timer_id,
	input  logic [31:0] ticks,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        result_kind,
	output logic [3:0]  expired_id,
	output logic        status,
	output logic        was_pending,
	output logic [31:0] next_delay,
	output logic        last
);

	localparam int IB = 4;
	localparam int NB = $clog2(NUM_TIMERS);
	localparam int LB = $clog2(NUM_TIMERS + 1);

	state_t               state_q, state_d;
	req_t                 req_q;
	logic [IB-1:0]        id_q;
	logic [TICK_BITS-1:0] t_q;
	logic [LB-1:0]        len_q;
	logic [LB-1:0]        pos_q;
	logic [NUM_TIMERS-1:0] active_q;
	logic                 st_q, pend_q;

	logic                 used  [NUM_TIMERS+1];
	logic [IB-1:0]        slot  [NUM_TIMERS+1];
	logic [TICK_BITS-1:0] delta [NUM_TIMERS+1];
	logic [NUM_TIMERS-1:0] sel, after;
	cmd_t                 cmd;
	logic [TICK_BITS-1:0] ins_delta;

	logic                 ov_q;
	logic                 kind_q, ost_q, opend_q, last_q;
	logic [3:0]           oid_q;
	logic [31:0]          odel_q;
	logic                 emit;
	logic                 e_kind, e_st, e_pend, e_last;
	logic [3:0]           e_id;
	logic [31:0]          e_del;

	logic                 id_ok;
	logic [NB-1:0]        id_idx;
	logic [NB-1:0]        pos_idx;
	logic                 hit;
	logic [NB-1:0]        hit_idx;
	logic                 space;

	assign id_ok  = (32'(id_q) < 32'(NUM_TIMERS));
	assign id_idx = NB'(id_q);
	assign pos_idx = pos_q[NB-1:0];
	assign space  = ~ov_q | out_ready;
	assign in_ready = (state_q == ST_IDLE);

	assign used[NUM_TIMERS]  = 1'b0;
	assign slot[NUM_TIMERS]  = '0;
	assign delta[NUM_TIMERS] = '0;

	always_comb begin
		hit = 1'b0;
		hit_idx = '0;
		for (int k = 0; k < NUM_TIMERS; k++) begin
			if (!hit && used[k] && slot[k] == id_q) begin
				hit = 1'b1;
				hit_idx = NB'(k);
			end
		end
	end

	genvar g;
	generate
		for (g = 0; g < NUM_TIMERS; g++) begin : g_cell
			if (g == 0) begin : g_head
				dltq_cell #(.ID_BITS(IB), .TICK_BITS(TICK_BITS)) u_cell (
					.clk, .arst_n, .cmd, .sel(sel[g]), .after(after[g]),
					.new_slot(id_q), .new_delta(t_q), .age(t_q),
					.prev_used(1'b0), .prev_slot('0), .prev_delta('0),
					.next_used(used[g+1]), .next_slot(slot[g+1]),
					.next_delta(delta[g+1]),
					.used(used[g]), .slot(slot[g]), .delta(delta[g])
				);
			end else begin : g_body
				dltq_cell #(.ID_BITS(IB), .TICK_BITS(TICK_BITS)) u_cell (
					.clk, .arst_n, .cmd, .sel(sel[g]), .after(after[g]),
					.new_slot(id_q), .new_delta(t_q), .age(t_q),
					.prev_used(used[g-1]), .prev_slot(slot[g-1]),
					.prev_delta((g == 0) ? delta[g-1] :
						(sel[g-1] ? ins_delta : delta[g-1])),
					.next_used(used[g+1]), .next_slot(slot[g+1]),
					.next_delta(delta[g+1]),
					.used(used[g]), .slot(slot[g]), .delta(delta[g])
				);
			end
		end
	endgenerate

	// The successor of an inserted entry is shortened by the new delay.
	assign ins_delta = delta[pos_idx] - t_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			len_q    <= '0;
			active_q <= '0;
			ov_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
			case (cmd)
				CMD_INSERT: begin
					len_q <= len_q + 1'b1;
					active_q[id_idx] <= 1'b1;
				end
				CMD_DELETE: begin
					len_q <= len_q - 1'b1;
				end
				CMD_POP: begin
					len_q <= len_q - 1'b1;
					active_q[NB'(slot[0])] <= 1'b0;
				end
				default: begin
				end
			endcase
			if (state_q == ST_REMOVE && id_ok) begin
				active_q[id_idx] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_q  <= req_t'(req_type);
			id_q   <= timer_id;
			t_q    <= TICK_BITS'(ticks);
			pos_q  <= '0;
			st_q   <= 1'b0;
			pend_q <= 1'b0;
		end
		if (state_q == ST_REMOVE) begin
			pend_q <= id_ok && active_q[id_idx];
			pos_q  <= '0;
		end
		if (state_q == ST_ADD && cmd == CMD_NONE && pos_q < len_q) begin
			if (id_ok && !active_q[id_idx] && t_q >= delta[pos_idx]) begin
				t_q   <= t_q - delta[pos_idx];
				pos_q <= pos_q + 1'b1;
			end
		end
		if (state_q == ST_ADD && id_ok && active_q[id_idx]) begin
			st_q <= 1'b1;
		end
		if (cmd == CMD_POP) begin
			t_q <= t_q - delta[0];
		end
		if (emit) begin
			kind_q  <= e_kind;
			oid_q   <= e_id;
			ost_q   <= e_st;
			opend_q <= e_pend;
			odel_q  <= e_del;
			last_q  <= e_last;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = CMD_NONE;
		sel     = '0;
		after   = '0;
		emit    = 1'b0;
		e_kind  = 1'b1;
		e_id    = '0;
		e_st    = 1'b0;
		e_pend  = 1'b0;
		e_del   = '0;
		e_last  = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (req_t'(req_type))
						REQ_ADD:      state_d = ST_ADD;
						REQ_DISPATCH: state_d = ST_DISP;
						default:      state_d = ST_REMOVE;
					endcase
				end
			end
			ST_REMOVE: begin
				if (id_ok && active_q[id_idx] && hit) begin
					cmd = CMD_DELETE;
					for (int k = 0; k < NUM_TIMERS; k++) begin
						sel[k]   = (NB'(k) == hit_idx);
						after[k] = (NB'(k) > hit_idx);
					end
				end
				state_d = (req_q == REQ_MODIFY) ? ST_ADD : ST_ANSWER;
			end
			ST_ADD: begin
				if (!id_ok || active_q[id_idx]) begin
					state_d = ST_ANSWER;
				end else if (pos_q < len_q && t_q >= delta[pos_idx]) begin
					state_d = ST_ADD;
				end else begin
					if (len_q < LB'(NUM_TIMERS)) begin
						cmd = CMD_INSERT;
						for (int k = 0; k < NUM_TIMERS; k++) begin
							sel[k]   = (LB'(k) == pos_q);
							after[k] = (LB'(k) > pos_q);
						end
					end
					state_d = ST_ANSWER;
				end
			end
			ST_DISP: begin
				if (space) begin
					if (used[0] && delta[0] <= t_q) begin
						cmd    = CMD_POP;
						emit   = 1'b1;
						e_kind = 1'b0;
						e_id   = slot[0];
						e_last = 1'b0;
					end else begin
						cmd    = CMD_AGE;
						sel[0] = 1'b1;
						emit   = 1'b1;
						e_del  = used[0] ? 32'((delta[0] > t_q) ? delta[0] - t_q : '0) : '0;
						state_d = ST_IDLE;
					end
				end
			end
			ST_ANSWER: begin
				if (space) begin
					emit = 1'b1;
					e_st = st_q;
					e_pend = (req_q == REQ_REMOVE) ? pend_q : 1'b0;
					if (req_q == REQ_REMOVE) begin
						e_st = 1'b0;
					end
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid   = ov_q;
	assign result_kind = kind_q;
	assign expired_id  = oid_q;
	assign status      = ost_q;
	assign was_pending = opend_q;
	assign next_delay  = odel_q;
	assign last        = last_q;

endmodule

// ----- tb/dltq_checker.sv -----
`timescale 1ns / 100ps
module dltq_checker import dltq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [3:0]  timer_id,
	input  logic [31:0] ticks,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        result_kind,
	input  logic [3:0]  expired_id,
	input  logic        status,
	input  logic        was_pending,
	input  logic [31:0] next_delay,
	input  logic        last,
	output int          fail_count,
	output int          pending_count
);

	typedef struct packed {
		logic        kind;
		logic [3:0]  id;
		logic        busy;
		logic        pend;
		logic [31:0] delay;
		logic        fin;
	} timer_result_t;

	logic [3:0]  slot_of [16];
	logic [31:0] delta_of [16];
	int          qlen;
	logic        active [16];
	timer_result_t answers [$];

	assign pending_count = answers.size();

	function automatic logic enqueue_timer(input logic [3:0] id, input logic [31:0] t);
		int i;
		if (active[id])
			return 1'b1;
		for (i = 0; i < qlen; i++) begin
			if (t < delta_of[i]) begin
				delta_of[i] -= t;
				break;
			end
			t -= delta_of[i];
		end
		for (int j = qlen; j > i; j--) begin
			slot_of[j] = slot_of[j - 1];
			delta_of[j] = delta_of[j - 1];
		end
		slot_of[i] = id;
		delta_of[i] = t;
		qlen++;
		active[id] = 1'b1;
		return 1'b0;
	endfunction

	function automatic logic cancel_timer(input logic [3:0] id);
		int i;
		if (!active[id])
			return 1'b0;
		for (i = 0; i < qlen; i++)
			if (slot_of[i] == id)
				break;
		active[id] = 1'b0;
		if (i + 1 < qlen)
			delta_of[i + 1] += delta_of[i];
		for (int j = i; j + 1 < qlen; j++) begin
			slot_of[j] = slot_of[j + 1];
			delta_of[j] = delta_of[j + 1];
		end
		qlen--;
		return 1'b1;
	endfunction

	function automatic void predict_request(input req_t rq, input logic [3:0] id,
			input logic [31:0] t);
		logic r;
		case (rq)
			REQ_ADD: begin
				r = enqueue_timer(id, t);
				answers.push_back('{1'b1, 4'd0, r, 1'b0, 32'd0, 1'b1});
			end
			REQ_MODIFY: begin
				r = cancel_timer(id);
				r = enqueue_timer(id, t);
				answers.push_back('{1'b1, 4'd0, r, 1'b0, 32'd0, 1'b1});
			end
			REQ_REMOVE: begin
				r = cancel_timer(id);
				answers.push_back('{1'b1, 4'd0, 1'b0, r, 32'd0, 1'b1});
			end
			default: begin
				while (qlen > 0 && delta_of[0] <= t) begin
					t -= delta_of[0];
					answers.push_back('{1'b0, slot_of[0], 1'b0, 1'b0, 32'd0, 1'b0});
					active[slot_of[0]] = 1'b0;
					for (int j = 0; j + 1 < qlen; j++) begin
						slot_of[j] = slot_of[j + 1];
						delta_of[j] = delta_of[j + 1];
					end
					qlen--;
				end
				if (qlen == 0) begin
					answers.push_back('{1'b1, 4'd0, 1'b0, 1'b0, 32'd0, 1'b1});
				end else begin
					delta_of[0] = (delta_of[0] > t) ? delta_of[0] - t : 32'd0;
					answers.push_back('{1'b1, 4'd0, 1'b0, 1'b0, delta_of[0], 1'b1});
				end
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		timer_result_t e;
		if (!arst_n) begin
			qlen = 0;
			fail_count = 0;
			for (int k = 0; k < 16; k++)
				active[k] = 1'b0;
			answers.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (answers.size() == 0) begin
					$error("result with no expectation waiting");
					fail_count++;
				end else begin
					e = answers.pop_front();
					if (result_kind !== e.kind) begin
						$error("result_kind expected %0d actual %0d", e.kind, result_kind);
						fail_count++;
					end
					if (expired_id !== e.id) begin
						$error("expired_id expected %0d actual %0d", e.id, expired_id);
						fail_count++;
					end
					if (status !== e.busy) begin
						$error("status expected %0d actual %0d", e.busy, status);
						fail_count++;
					end
					if (was_pending !== e.pend) begin
						$error("was_pending expected %0d actual %0d", e.pend, was_pending);
						fail_count++;
					end
					if (next_delay !== e.delay) begin
						$error("next_delay expected %0d actual %0d", e.delay, next_delay);
						fail_count++;
					end
					if (last !== e.fin) begin
						$error("last expected %0d actual %0d", e.fin, last);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready)
				predict_request(req_t'(req_type), timer_id, ticks);
		end
	end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
module tb;
	import dltq_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  req_type;
	logic [3:0]  timer_id;
	logic [31:0] ticks;
	logic        out_valid;
	logic        out_ready;
	logic        result_kind;
	logic [3:0]  expired_id;
	logic        status;
	logic        was_pending;
	logic [31:0] next_delay;
	logic        last;
	int          fail_count;
	int          pending_count;
	int          gap_left;
	int          burst_left;

	delta_list_timer_queue uut (.*);
	dltq_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("tb failed");
		$finish;
	end

	// Receiver stalls in runs, with long stretches of full readiness.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 3) == 0)
				out_ready = 1'b1;
			else if ($urandom_range(0, 5) == 0)
				out_ready = 1'b0;
			else if ($urandom_range(0, 1) == 0)
				out_ready = ($urandom_range(0, 2) != 0);
		end
	end

	task automatic send_request(input req_t rq, input logic [3:0] id, input logic [31:0] t);
		if (burst_left == 0) begin
			repeat (gap_left) @(negedge clk);
			burst_left = $urandom_range(1, 8);
			gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
		end
		burst_left--;
		in_valid = 1'b1;
		req_type = rq;
		timer_id = id;
		ticks = t;
		while (!in_ready) @(negedge clk);
		@(posedge clk);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	function automatic logic [31:0] pick_ticks();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
			2: return 32'd0;
			default: return $urandom_range(0, 300);
		endcase
	endfunction

	initial begin
		req_t rq;
		in_valid = 1'b0;
		req_type = REQ_ADD;
		timer_id = 4'd0;
		ticks = 32'd0;
		burst_left = 0;
		gap_left = 0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_request(REQ_DISPATCH, 4'd0, 32'd5);
		send_request(REQ_REMOVE, 4'd3, 32'd0);
		send_request(REQ_ADD, 4'd0, 32'd100);
		send_request(REQ_ADD, 4'd15, 32'd100);
		send_request(REQ_ADD, 4'd7, 32'd40);
		send_request(REQ_ADD, 4'd7, 32'd10);
		send_request(REQ_ADD, 4'd9, 32'hFFFF_FFFF);
		send_request(REQ_ADD, 4'd1, 32'd0);
		send_request(REQ_MODIFY, 4'd7, 32'd150);
		send_request(REQ_MODIFY, 4'd2, 32'd60);
		send_request(REQ_REMOVE, 4'd0, 32'd0);
		send_request(REQ_REMOVE, 4'd0, 32'd0);
		send_request(REQ_DISPATCH, 4'd0, 32'd0);
		send_request(REQ_DISPATCH, 4'd0, 32'd70);
		for (int k = 0; k < 16; k++)
			send_request(REQ_ADD, k[3:0], 32'(k * 3));
		send_request(REQ_DISPATCH, 4'd0, 32'hFFFF_FFFF);
		send_request(REQ_DISPATCH, 4'd0, 32'hFFFF_FFFF);

		for (int n = 0; n < 198; n++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: rq = REQ_ADD;
				4, 5: rq = REQ_MODIFY;
				6: rq = REQ_REMOVE;
				default: rq = REQ_DISPATCH;
			endcase
			send_request(rq, 4'($urandom_range(0, 15)),
				(rq == REQ_DISPATCH && $urandom_range(0, 1)) ?
				32'($urandom_range(0, 200)) : pick_ticks());
		end

		while (pending_count != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
